>>> hdl/mnva_pkg.sv
// Types, codes and constants shared by the MIDI note voice allocator.
// No dependencies; mnva_front, mnva_back and the top level import it.
`default_nettype none

package mnva_pkg;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  // Register index taken from paddr[2] (byte address 4*i)
  localparam logic REG_RELEASE_ENABLE = 1'b0;
  localparam logic RELEASE_ENABLE_RST = 1'b1;

  localparam logic [7:0] ST_NOTE_ON  = 8'h90;
  localparam logic [7:0] ST_NOTE_OFF = 8'h80;

  localparam int unsigned STEP_W = 20;
  localparam logic [STEP_W-1:0] STEP_MAX = 20'hFFFFF;

  typedef enum logic [1:0] {
    PS_STATUS,
    PS_KEY,
    PS_VEL
  } parse_state_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LOOK,
    BK_APPLY
  } back_state_t;

  typedef enum logic [2:0] {
    OP_ABSORB,
    OP_ON,
    OP_OFF,
    OP_OFF_IGN,
    OP_DECAY
  } cmd_op_t;

  typedef enum logic [2:0] {
    EV_ABSORB  = 3'd0,
    EV_START   = 3'd1,
    EV_RELEASE = 3'd2,
    EV_IGNORED = 3'd3,
    EV_DECAY   = 3'd4
  } event_kind_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
  } req_t;

  typedef struct packed {
    logic [2:0]        event_kind;
    logic [2:0]        voice_index;
    logic [6:0]        note_key;
    logic [6:0]        note_velocity;
    logic [STEP_W-1:0] phase_step;
    logic [7:0]        active_mask;
  } rsp_t;

  // Classified message handed from the parser to the voice engine
  typedef struct packed {
    cmd_op_t    op;
    logic [6:0] key;
    logic [6:0] vel;
  } cmd_t;

endpackage

`default_nettype wire

>>> hdl/mnva_fifo.sv
// Small synchronous queue of a generic item type (registers, fall-through read).
// Depends on nothing; instantiated twice by the top level.
`default_nettype none

module mnva_fifo #(
  parameter type         T     = logic,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire T     wdata,
  output logic      full,
  input  wire logic pop,
  output T          rdata,
  output logic      empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  T              mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          wr;
  logic          rd;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign wr    = push && !full;
  assign rd    = pop && !empty;
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (wr && !rd) |=> count == $past(count) + 1'b1)
    else $error("queue count did not advance on write");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (rd && !wr) |=> count == $past(count) - 1'b1)
    else $error("queue count did not drop on read");

endmodule

`default_nettype wire

>>> hdl/mnva_front.sv
// Front end: MIDI byte parser that turns accepted items into voice commands.
// Depends on mnva_pkg; feeds the command queue in the top level.
`default_nettype none

module mnva_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire mnva_pkg::req_t req,
  input  wire logic          release_enable,
  input  wire logic          q_full,
  output logic               full,
  output logic               cmd_push,
  output mnva_pkg::cmd_t     cmd
);

  import mnva_pkg::*;

  parse_state_t state;
  parse_state_t state_next;
  logic         pending_on;
  logic [6:0]   pending_key;
  logic         accept;
  logic         is_status;

  assign full      = q_full;
  assign accept    = push && !q_full;
  assign is_status = (req.data_byte == ST_NOTE_ON) || (req.data_byte == ST_NOTE_OFF);

  always_comb begin
    state_next = state;
    if (accept && !req.req_type) begin
      case (state)
        PS_STATUS: state_next = is_status ? PS_KEY : PS_STATUS;
        PS_KEY:    state_next = PS_VEL;
        PS_VEL:    state_next = PS_STATUS;
        default:   state_next = PS_STATUS;
      endcase
    end
  end

  always_comb begin
    cmd_push = accept;
    cmd      = '{op: OP_ABSORB, key: 7'd0, vel: 7'd0};
    if (req.req_type) begin
      cmd.op = OP_DECAY;
    end else begin
      case (state)
        PS_VEL: begin
          cmd.key = pending_key;
          cmd.vel = req.data_byte[6:0];
          if (pending_on) begin
            cmd.op = OP_ON;
          end else if (release_enable) begin
            cmd.op = OP_OFF;
          end else begin
            cmd.op = OP_OFF_IGN;
          end
        end
        default: cmd.op = OP_ABSORB;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= PS_STATUS;
      pending_on  <= 1'b0;
      pending_key <= 7'd0;
    end else begin
      state <= state_next;
      if (accept && !req.req_type) begin
        case (state)
          PS_STATUS: begin
            if (is_status) begin
              pending_on <= (req.data_byte == ST_NOTE_ON);
            end
          end
          PS_KEY: pending_key <= req.data_byte[6:0];
          PS_VEL: begin
            pending_on  <= 1'b0;
            pending_key <= 7'd0;
          end
          default: ;
        endcase
      end
    end
  end

  a_key_to_vel: assert property (@(posedge clk) disable iff (rst)
    (accept && !req.req_type && state == PS_KEY) |=> state == PS_VEL)
    else $error("key byte did not advance parser");

  a_tick_keeps_parser: assert property (@(posedge clk) disable iff (rst)
    (accept && req.req_type) |=> $stable(state) && $stable(pending_key)
      && $stable(pending_on))
    else $error("decay tick disturbed parser");

  a_vel_closes: assert property (@(posedge clk) disable iff (rst)
    (accept && !req.req_type && state == PS_VEL)
      |=> state == PS_STATUS && !pending_on && pending_key == 7'd0)
    else $error("velocity byte did not close message");

endmodule

`default_nettype wire

>>> hdl/mnva_back.sv
// Back end: voice engine that applies commands to the voice bank and forms results.
// Depends on mnva_pkg; reads the command queue and fills the result queue.
`default_nettype none

module mnva_back #(
  parameter int unsigned VOICES          = 8,
  parameter int unsigned SAMPLE_RATE     = 20000,
  parameter int unsigned PHASE_FRAC_BITS = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire mnva_pkg::cmd_t cmd_q,
  input  wire logic           cmd_empty,
  output logic                cmd_pop,
  input  wire logic           res_full,
  output logic                res_push,
  output mnva_pkg::rsp_t      rsp_d
);

  import mnva_pkg::*;

  localparam int unsigned VW    = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned MASKN = (VOICES < 8) ? VOICES : 8;

  typedef logic [STEP_W-1:0] step_tab_t [128];

  // Step per key: 1.059^(key-69) in Q40, times 440, scaled to the phase format
  function automatic step_tab_t build_steps();
    step_tab_t   tab;
    logic [63:0] g;
    int          k;
    int          j;
    for (k = 0; k < 128; k++) begin
      g = 64'd1 << 40;
      for (j = 69; j < k; j++) begin
        g = g * 64'd1059 / 64'd1000;
      end
      for (j = k; j < 69; j++) begin
        g = g * 64'd1000 / 64'd1059;
      end
      g = g * 64'd440;
      g = g >> (40 - PHASE_FRAC_BITS);
      g = g / 64'(SAMPLE_RATE);
      tab[k] = (g > 64'(STEP_MAX)) ? STEP_MAX : g[STEP_W-1:0];
    end
    return tab;
  endfunction

  localparam step_tab_t STEP_TABLE = build_steps();

  back_state_t       state;
  back_state_t       state_next;
  cmd_t              cur;
  logic [STEP_W-1:0] step;
  logic [6:0]        voice_key [VOICES];
  logic [6:0]        voice_velocity [VOICES];
  logic [6:0]        key_next [VOICES];
  logic [6:0]        vel_next [VOICES];
  logic [VW-1:0]     next_voice;
  logic [VW-1:0]     next_voice_next;
  logic [VW+2:0]     voice_ext;

  assign voice_ext = (VW + 3)'(next_voice);

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE:  if (!cmd_empty) state_next = BK_LOOK;
      BK_LOOK:  state_next = BK_APPLY;
      BK_APPLY: if (!res_full) state_next = BK_IDLE;
      default:  state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop  = 1'b0;
    res_push = 1'b0;
    case (state)
      BK_IDLE:  cmd_pop = !cmd_empty;
      BK_APPLY: res_push = !res_full;
      default:  ;
    endcase
  end

  always_comb begin
    key_next        = voice_key;
    vel_next        = voice_velocity;
    next_voice_next = next_voice;
    rsp_d           = '0;
    case (cur.op)
      OP_DECAY: begin
        rsp_d.event_kind = EV_DECAY;
        for (int i = 0; i < VOICES; i++) begin
          vel_next[i] = voice_velocity[i] >> 1;
          if (vel_next[i] == 7'd0) begin
            key_next[i] = 7'd0;
          end
        end
      end
      OP_ON, OP_OFF: begin
        rsp_d.note_key      = cur.key;
        rsp_d.note_velocity = cur.vel;
        rsp_d.event_kind    = EV_RELEASE;
        for (int i = 0; i < VOICES; i++) begin
          if (voice_key[i] == cur.key) begin
            key_next[i] = 7'd0;
            vel_next[i] = 7'd0;
          end
        end
        if (cur.op == OP_ON && cur.vel != 7'd0) begin
          key_next[next_voice] = cur.key;
          vel_next[next_voice] = cur.vel;
          rsp_d.event_kind     = EV_START;
          rsp_d.voice_index    = voice_ext[2:0];
          rsp_d.phase_step     = step;
          next_voice_next      = (next_voice == VW'(VOICES - 1)) ? '0 : next_voice + 1'b1;
        end
      end
      OP_OFF_IGN: begin
        rsp_d.note_key      = cur.key;
        rsp_d.note_velocity = cur.vel;
        rsp_d.event_kind    = EV_IGNORED;
      end
      default: rsp_d.event_kind = EV_ABSORB;
    endcase
    for (int i = 0; i < MASKN; i++) begin
      rsp_d.active_mask[i] = (vel_next[i] != 7'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur <= cmd_q;
    end
    if (state == BK_LOOK) begin
      step <= STEP_TABLE[cur.key];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_IDLE;
      next_voice <= '0;
      for (int i = 0; i < VOICES; i++) begin
        voice_key[i]      <= 7'd0;
        voice_velocity[i] <= 7'd0;
      end
    end else begin
      state <= state_next;
      if (res_push) begin
        voice_key      <= key_next;
        voice_velocity <= vel_next;
        next_voice     <= next_voice_next;
      end
    end
  end

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (state == BK_APPLY && res_full) |=> state == BK_APPLY && $stable(cur))
    else $error("command lost while result queue full");

  a_start_advances: assert property (@(posedge clk) disable iff (rst)
    (res_push && rsp_d.event_kind == EV_START)
      |=> (VOICES == 1) || (next_voice != $past(next_voice)))
    else $error("round robin pointer did not advance");

  a_silent_voice_clear: assert property (@(posedge clk) disable iff (rst)
    voice_velocity[0] == 7'd0 |-> voice_key[0] == 7'd0)
    else $error("silent voice still holds a key");

endmodule

`default_nettype wire

>>> hdl/midi_note_voice_allocator_unit.sv
// MIDI note voice allocator: parser front end, command queue, voice engine, result queue.
// Each result passes the command queue and the engine's pop, lookup and apply states.
// The engine applies each command before popping the next; a full result queue stalls it.
// The front takes items until two commands wait, so up to three enter back to back.
// Reset (rst, synchronous): parser idle, voices silent, round robin at 0, release on.
// Depends on mnva_pkg, mnva_fifo, mnva_front and mnva_back.
`default_nettype none

module midi_note_voice_allocator_unit #(
  parameter int unsigned VOICES          = 8,
  parameter int unsigned SAMPLE_RATE     = 20000,
  parameter int unsigned PHASE_FRAC_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                push,
  output logic                                     full,
  input  wire mnva_pkg::req_t                      req,
  output logic                                     empty,
  input  wire logic                                pop,
  output mnva_pkg::rsp_t                           rsp,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [mnva_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [mnva_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [mnva_pkg::APB_DATA_W-1:0]          prdata,
  output logic                                     pready
);

  import mnva_pkg::*;

  logic   release_enable;
  logic   cfg_wr;
  logic   cmdq_full;
  logic   cmdq_empty;
  logic   cmdq_pop;
  logic   cmd_push;
  cmd_t   cmd_in;
  cmd_t   cmd_out;
  logic   res_full;
  logic   res_push;
  rsp_t   rsp_d;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_RELEASE_ENABLE) begin
      prdata[0] = release_enable;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      release_enable <= RELEASE_ENABLE_RST;
    end else if (cfg_wr && paddr[2] == REG_RELEASE_ENABLE) begin
      release_enable <= pwdata[0];
    end
  end

  mnva_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .req            (req),
    .release_enable (release_enable),
    .q_full         (cmdq_full),
    .full           (full),
    .cmd_push       (cmd_push),
    .cmd            (cmd_in)
  );

  mnva_fifo #(
    .T     (cmd_t),
    .DEPTH (2)
  ) u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmdq_full),
    .pop   (cmdq_pop),
    .rdata (cmd_out),
    .empty (cmdq_empty)
  );

  mnva_back #(
    .VOICES          (VOICES),
    .SAMPLE_RATE     (SAMPLE_RATE),
    .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_q     (cmd_out),
    .cmd_empty (cmdq_empty),
    .cmd_pop   (cmdq_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .rsp_d     (rsp_d)
  );

  mnva_fifo #(
    .T     (rsp_t),
    .DEPTH (2)
  ) u_resq (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (rsp_d),
    .full  (res_full),
    .pop   (pop),
    .rdata (rsp),
    .empty (empty)
  );

endmodule

`default_nettype wire

>>> test/tb_midi_note_voice_allocator_unit.sv
// Self-checking bench for midi_note_voice_allocator_unit: parses MIDI bytes and decay ticks
// against a cycle-free voice model and scoreboards every response. Needs mnva_pkg and the RTL.
module tb_midi_note_voice_allocator_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import mnva_pkg::*;

  localparam int unsigned NUM_VOICES = 8;
  localparam int unsigned RATE_HZ    = 20000;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam logic [APB_ADDR_W-1:0] RELEASE_EN_ADDR = {REG_RELEASE_ENABLE, 2'b00};

  logic clk;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  req_t req = '0;
  logic empty;
  logic pop = 1'b0;
  rsp_t rsp;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  midi_note_voice_allocator_unit #(
    .VOICES(NUM_VOICES),
    .SAMPLE_RATE(RATE_HZ),
    .PHASE_FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .req(req),
    .empty(empty), .pop(pop), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Voice model state
  parse_state_t parse_st = PS_STATUS;
  logic pend_on = 1'b0;
  logic [6:0] pend_key = '0;
  logic [6:0] vkey [NUM_VOICES];
  logic [6:0] vvel [NUM_VOICES];
  logic [2:0] next_voice = '0;
  logic rel_en = RELEASE_ENABLE_RST;

  req_t midi_in_q[$];
  rsp_t voice_events_q[$];
  int items_queued = 0;
  int bad_events = 0;
  int cycles = 0;
  bit gaps_on = 1'b1;
  int send_gap = 0;
  int recv_gap = 0;

  initial begin
    for (int i = 0; i < NUM_VOICES; i++) begin
      vkey[i] = '0;
      vvel[i] = '0;
    end
  end

  // Q40 pitch ratio 1.059^(key-69), scaled by 440 Hz down to the phase format
  function automatic logic [STEP_W-1:0] pitch_step(logic [6:0] key);
    logic [63:0] g;
    int n;
    g = 64'd1 << 40;
    n = int'(key) - 69;
    while (n > 0) begin
      g = g * 64'd1059 / 64'd1000;
      n--;
    end
    while (n < 0) begin
      g = g * 64'd1000 / 64'd1059;
      n++;
    end
    g = (g * 64'd440) >> (40 - FRAC_BITS);
    g = g / 64'(RATE_HZ);
    if (g > 64'(STEP_MAX)) return STEP_MAX;
    return g[STEP_W-1:0];
  endfunction

  function automatic void release_voices(logic [6:0] key);
    int i;
    for (i = 0; i < NUM_VOICES; i++) begin
      if (vkey[i] == key) begin
        vkey[i] = '0;
        vvel[i] = '0;
      end
    end
  endfunction

  function automatic rsp_t allocate_voice(req_t r);
    rsp_t o;
    logic [6:0] vel;
    int i;
    o = '0;
    o.event_kind = EV_ABSORB;
    if (r.req_type) begin
      for (i = 0; i < NUM_VOICES; i++) begin
        vvel[i] = vvel[i] >> 1;
        if (vvel[i] == '0) vkey[i] = '0;
      end
      o.event_kind = EV_DECAY;
    end else if (parse_st == PS_KEY) begin
      pend_key = r.data_byte[6:0];
      parse_st = PS_VEL;
    end else if (parse_st == PS_VEL) begin
      vel = r.data_byte[6:0];
      parse_st = PS_STATUS;
      o.note_key = pend_key;
      o.note_velocity = vel;
      if (pend_on) begin
        release_voices(pend_key);
        if (vel == '0) begin
          o.event_kind = EV_RELEASE;
        end else begin
          vkey[next_voice] = pend_key;
          vvel[next_voice] = vel;
          o.phase_step = pitch_step(pend_key);
          o.voice_index = next_voice;
          o.event_kind = EV_START;
          next_voice = next_voice + 3'd1;
        end
      end else if (rel_en) begin
        release_voices(pend_key);
        o.event_kind = EV_RELEASE;
      end else begin
        o.event_kind = EV_IGNORED;
      end
      pend_on = 1'b0;
      pend_key = '0;
    end else begin
      parse_st = PS_STATUS;
      if (r.data_byte == ST_NOTE_ON) begin
        pend_on = 1'b1;
        parse_st = PS_KEY;
      end else if (r.data_byte == ST_NOTE_OFF) begin
        pend_on = 1'b0;
        parse_st = PS_KEY;
      end
    end
    for (i = 0; i < NUM_VOICES; i++) o.active_mask[i] = (vvel[i] != '0);
    return o;
  endfunction

  // Sender: one item per transfer, random gaps while enabled
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (send_gap > 0) begin
      send_gap--;
      push <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 11) == 0) begin
      send_gap = $urandom_range(1, 16) - 1;
      push <= 1'b0;
    end else if (midi_in_q.size() != 0) begin
      push <= 1'b1;
      req <= midi_in_q[0];
    end else begin
      push <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && push && !full) begin
      voice_events_q.push_back(allocate_voice(req));
      void'(midi_in_q.pop_front());
    end
  end

  // Receiver: random stalls while enabled
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      pop <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 11) == 0) begin
      recv_gap = $urandom_range(1, 16) - 1;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && pop && !empty) begin
      if (voice_events_q.size() == 0) begin
        if (bad_events < 10)
          $display("unexpected event: kind=%0d vidx=%0d key=%0d vel=%0d step=%05h mask=%02h",
                   rsp.event_kind, rsp.voice_index, rsp.note_key, rsp.note_velocity,
                   rsp.phase_step, rsp.active_mask);
        bad_events++;
      end else begin
        want = voice_events_q.pop_front();
        if (rsp.event_kind !== want.event_kind || rsp.voice_index !== want.voice_index ||
            rsp.note_key !== want.note_key || rsp.note_velocity !== want.note_velocity ||
            rsp.phase_step !== want.phase_step || rsp.active_mask !== want.active_mask) begin
          if (bad_events < 10) begin
            $display("event mismatch: exp kind=%0d vidx=%0d key=%0d vel=%0d step=%05h mask=%02h",
                     want.event_kind, want.voice_index, want.note_key, want.note_velocity,
                     want.phase_step, want.active_mask);
            $display("                got kind=%0d vidx=%0d key=%0d vel=%0d step=%05h mask=%02h",
                     rsp.event_kind, rsp.voice_index, rsp.note_key, rsp.note_velocity,
                     rsp.phase_step, rsp.active_mask);
          end
          bad_events++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic queue_item(logic tick, logic [7:0] b);
    req_t r;
    r.req_type = tick;
    r.data_byte = b;
    midi_in_q.push_back(r);
    items_queued++;
  endtask

  task automatic drain();
    while (midi_in_q.size() != 0 || voice_events_q.size() != 0) @(negedge clk);
  endtask

  // Write the register over APB, then read it back
  task automatic set_release_enable(logic en);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= RELEASE_EN_ADDR;
    pwdata <= {{(APB_DATA_W-1){1'b0}}, en};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    rel_en = en;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== {{(APB_DATA_W-1){1'b0}}, rel_en}) begin
      if (bad_events < 10)
        $display("release_enable readback: exp %0h got %0h", rel_en, prdata);
      bad_events++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [6:0] pick_key();
    case ($urandom_range(0, 9))
      0: return 7'd0;
      1: return 7'd127;
      2: return 7'd60;
      3: return 7'd64;
      4: return 7'd67;
      5: return 7'd69;
      default: return 7'($urandom_range(0, 127));
    endcase
  endfunction

  function automatic logic [6:0] pick_vel();
    case ($urandom_range(0, 9))
      0: return 7'd0;
      1: return 7'd127;
      2: return 7'd1;
      default: return 7'($urandom_range(1, 127));
    endcase
  endfunction

  // Mostly complete note messages, plus ticks, stray bytes and cut-short messages
  task automatic gen_traffic(int n);
    int target;
    int pick;
    logic hi;
    logic [7:0] st;
    target = items_queued + n;
    while (items_queued < target) begin
      pick = $urandom_range(0, 99);
      st = ($urandom_range(0, 2) != 0) ? ST_NOTE_ON : ST_NOTE_OFF;
      if (pick < 60) begin
        queue_item(1'b0, st);
        if ($urandom_range(0, 9) == 0) queue_item(1'b1, 8'($urandom_range(0, 255)));
        hi = ($urandom_range(0, 7) == 0);
        queue_item(1'b0, {hi, pick_key()});
        hi = ($urandom_range(0, 7) == 0);
        queue_item(1'b0, {hi, pick_vel()});
      end else if (pick < 75) begin
        queue_item(1'b1, 8'($urandom_range(0, 255)));
      end else if (pick < 88) begin
        queue_item(1'b0, 8'($urandom_range(0, 255)));
      end else begin
        queue_item(1'b0, st);
        queue_item(1'b0, 8'($urandom_range(128, 255)));
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    queue_item(1'b0, 8'h3C);        // data byte with no status
    queue_item(1'b0, 8'hB0);        // unsupported status
    queue_item(1'b0, ST_NOTE_ON);   // highest key, loudest
    queue_item(1'b0, 8'd127);
    queue_item(1'b0, 8'd127);
    queue_item(1'b0, ST_NOTE_ON);   // lowest key, softest
    queue_item(1'b0, 8'd0);
    queue_item(1'b0, 8'd1);
    queue_item(1'b0, ST_NOTE_ON);   // key and velocity with the top bit set
    queue_item(1'b0, 8'hC5);
    queue_item(1'b0, 8'hFF);
    queue_item(1'b0, ST_NOTE_ON);   // tick in the middle of a message
    queue_item(1'b1, 8'h00);
    queue_item(1'b0, 8'h40);
    queue_item(1'b0, 8'h50);
    queue_item(1'b0, ST_NOTE_ON);   // zero velocity acts as release
    queue_item(1'b0, 8'd127);
    queue_item(1'b0, 8'd0);
    queue_item(1'b0, ST_NOTE_OFF);  // key zero also matches silent voices
    queue_item(1'b0, 8'd0);
    queue_item(1'b0, 8'h40);
    queue_item(1'b1, 8'hFF);
    drain();

    set_release_enable(1'b0);
    queue_item(1'b0, ST_NOTE_OFF);  // note-off dropped while release is off
    queue_item(1'b0, 8'h45);
    queue_item(1'b0, 8'h10);
    gen_traffic(480);
    drain();

    set_release_enable(1'b1);
    gen_traffic(500);
    drain();

    set_release_enable(1'b0);
    gen_traffic(450);
    drain();

    set_release_enable(1'b1);
    gaps_on = 1'b0;
    gen_traffic(500);
    drain();

    repeat (20) @(negedge clk);
    if (bad_events == 0 && voice_events_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
